// ----- rtl/jlps_pkg.sv -----
// ----------------------------------------------------------------------------
// jlps_pkg
// Shared types and codes of the job list priority scheduler.
// ----------------------------------------------------------------------------
package jlps_pkg;

    // Ring and active table depth, a power of two matching the 4-bit slot field
    localparam int TABLE_DEPTH = 16;

    // Function codes as they arrive on the input tuser
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_PICK   = 2'd1;
    localparam logic [1:0] FUNC_REPORT = 2'd2;

    // Outcome codes of a run report
    localparam logic [1:0] OUTCOME_DONE    = 2'd0;
    localparam logic [1:0] OUTCOME_STALLED = 2'd1;

    // Reset value of the full-run level register
    localparam logic [1:0] FULL_RUN_RESET = 2'd3;

    // Decoded command kinds
    typedef enum logic [1:0] {
        OP_ADD,
        OP_PICK,
        OP_REPORT,
        OP_NONE
    } op_t;

    // Command passed from front to back through the queue
    typedef struct packed {
        op_t         op;
        logic [15:0] list_id;
        logic [1:0]  list_priority;
        logic [1:0]  outcome;
    } cmd_t;

    // Result item, first field in the highest bits
    typedef struct packed {
        logic [31:0] dispatch_total;
        logic        yield_hint;
        logic        run_whole;
        logic [15:0] chosen_id;
        logic [3:0]  slot;
        logic        idle;
        logic        accepted;
    } res_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_INIT,
        ST_SCAN
    } state_t;

endpackage

// ----- rtl/jlps_front.sv -----
// ----------------------------------------------------------------------------
// jlps_front
// Input stage: registers an item and decodes its function into a command.
// ----------------------------------------------------------------------------
module jlps_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,    // list_id, list_priority, outcome
    input  logic [1:0]       s_tuser,    // func
    output logic             push_valid,
    input  logic             push_ready,
    output jlps_pkg::cmd_t   push_cmd
);
    import jlps_pkg::*;

    logic front_valid_reg;
    cmd_t front_cmd_reg;
    cmd_t front_cmd_next;

    // Stage is free when empty or being drained into the queue
    assign s_tready   = !front_valid_reg || push_ready;
    assign push_valid = front_valid_reg;
    assign push_cmd   = front_cmd_reg;

    // Decode the function code
    always_comb begin
        front_cmd_next.list_id       = s_tdata[15:0];
        front_cmd_next.list_priority = s_tdata[17:16];
        front_cmd_next.outcome       = s_tdata[19:18];
        unique case (s_tuser)
            FUNC_ADD:    front_cmd_next.op = OP_ADD;
            FUNC_PICK:   front_cmd_next.op = OP_PICK;
            FUNC_REPORT: front_cmd_next.op = OP_REPORT;
            default:     front_cmd_next.op = OP_NONE;
        endcase
    end

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_tready) begin
            front_valid_reg <= s_tvalid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            front_cmd_reg <= front_cmd_next;
        end
    end

endmodule

// ----- rtl/jlps_queue.sv -----
// ----------------------------------------------------------------------------
// jlps_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module jlps_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  jlps_pkg::cmd_t   push_cmd,
    output logic             pop_valid,
    input  logic             pop_ready,
    output jlps_pkg::cmd_t   pop_cmd
);
    import jlps_pkg::*;

    cmd_t       q_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push_fire;
    logic       pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = q_mem[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop_fire) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push_fire && !pop_fire) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop_fire && !push_fire) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/jlps_back.sv -----
// ----------------------------------------------------------------------------
// jlps_back
// Execution engine: ring, active table, slot selection scan and outcome
// handling, with the registered result item.
// ----------------------------------------------------------------------------
module jlps_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  jlps_pkg::cmd_t   pop_cmd,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output jlps_pkg::res_t   m_res
);
    import jlps_pkg::*;

    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam int CNTW = IDXW + 1;
    localparam logic [CNTW-1:0] DEPTH_C = CNTW'(TABLE_DEPTH);
    localparam logic [CNTW-1:0] STALL_NONE = '1;

    state_t state_reg, state_next;

    // Ring store
    logic [17:0]      ring_mem [TABLE_DEPTH];
    logic [17:0]      ring_rd_reg;
    logic [CNTW-1:0]  wr_ptr_reg;
    logic [CNTW-1:0]  rd_ptr_reg;
    logic [CNTW-1:0]  ring_fill;
    logic             ring_full;
    logic             ring_empty;

    // Active table
    logic [15:0]      act_id_reg   [TABLE_DEPTH];
    logic [1:0]       act_prio_reg [TABLE_DEPTH];
    logic [CNTW-1:0]  act_count_reg;

    // Scheduling state
    logic [CNTW-1:0]  stalled_reg;
    logic [IDXW-1:0]  dispatched_reg;
    logic             pending_reg;
    logic [31:0]      counter_reg;
    logic [1:0]       full_run_reg;

    // Scan registers
    logic [IDXW-1:0]  scan_idx_reg;
    logic [IDXW-1:0]  best_reg;
    logic [1:0]       best_prio_reg;
    logic [15:0]      best_id_reg;
    logic             stall_mode_reg;

    // Result register
    logic             m_tvalid_reg;
    res_t             m_res_reg;
    res_t             res_next;

    // Control signals
    logic             pop_fire;
    logic             load_ok;
    logic             stall_mode_now;
    logic [IDXW-1:0]  sel_idx;
    logic [15:0]      sel_id;
    logic [1:0]       sel_prio;
    logic             take;
    logic             scan_last;
    logic [IDXW-1:0]  fin_slot;
    logic [15:0]      fin_id;
    logic [1:0]       fin_prio;
    logic             report_ok;

    assign m_tvalid = m_tvalid_reg;
    assign m_res    = m_res_reg;

    assign ring_fill  = wr_ptr_reg - rd_ptr_reg;
    assign ring_full  = (ring_fill == DEPTH_C);
    assign ring_empty = (wr_ptr_reg == rd_ptr_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_fire && pop_cmd.op == OP_PICK) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_INIT;
            ST_INIT: begin
                if (act_count_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs and scan datapath
    always_comb begin
        pop_ready      = (state_reg == ST_IDLE) && !m_tvalid_reg;
        pop_fire       = pop_ready && pop_valid;
        load_ok        = (act_count_reg != DEPTH_C) && !ring_empty;
        stall_mode_now = (stalled_reg < act_count_reg);
        report_ok      = pending_reg && (CNTW'(dispatched_reg) < act_count_reg);
        if (state_reg == ST_INIT) begin
            sel_idx = stall_mode_now ? stalled_reg[IDXW-1:0] : '0;
        end else begin
            sel_idx = scan_idx_reg;
        end
        sel_id   = act_id_reg[sel_idx];
        sel_prio = act_prio_reg[sel_idx];
        if (stall_mode_reg) begin
            take = (scan_idx_reg != stalled_reg[IDXW-1:0]) && (sel_prio >= best_prio_reg);
        end else begin
            take = (sel_prio > best_prio_reg);
        end
        scan_last = (CNTW'(scan_idx_reg) == act_count_reg - CNTW'(1));
        fin_slot  = take ? scan_idx_reg : best_reg;
        fin_id    = take ? sel_id : best_id_reg;
        fin_prio  = take ? sel_prio : best_prio_reg;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            act_count_reg  <= '0;
            stalled_reg    <= STALL_NONE;
            dispatched_reg <= '0;
            pending_reg    <= 1'b0;
            counter_reg    <= '0;
            full_run_reg   <= FULL_RUN_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                full_run_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop_fire) begin
                        case (pop_cmd.op)
                            OP_ADD: begin
                                if (!ring_full) begin
                                    wr_ptr_reg <= wr_ptr_reg + CNTW'(1);
                                end
                                m_tvalid_reg <= 1'b1;
                            end
                            OP_REPORT: begin
                                if (report_ok) begin
                                    pending_reg <= 1'b0;
                                    if (pop_cmd.outcome == OUTCOME_DONE) begin
                                        act_count_reg <= act_count_reg - CNTW'(1);
                                    end else if (pop_cmd.outcome == OUTCOME_STALLED) begin
                                        stalled_reg <= CNTW'(dispatched_reg);
                                    end else begin
                                        stalled_reg <= STALL_NONE;
                                    end
                                end
                                m_tvalid_reg <= 1'b1;
                            end
                            OP_NONE: m_tvalid_reg <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                ST_LOAD: begin
                    if (load_ok) begin
                        act_count_reg <= act_count_reg + CNTW'(1);
                        rd_ptr_reg    <= rd_ptr_reg + CNTW'(1);
                    end
                end
                ST_INIT: begin
                    if (act_count_reg == '0) begin
                        m_tvalid_reg <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (scan_last) begin
                        dispatched_reg <= fin_slot;
                        pending_reg    <= 1'b1;
                        counter_reg    <= counter_reg + 32'd1;
                        m_tvalid_reg   <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Ring store, written at the write pointer, read registered at the read pointer
    always_ff @(posedge aclk) begin
        if (pop_fire && pop_cmd.op == OP_ADD && !ring_full) begin
            ring_mem[wr_ptr_reg[IDXW-1:0]] <= {pop_cmd.list_priority, pop_cmd.list_id};
        end
        ring_rd_reg <= ring_mem[rd_ptr_reg[IDXW-1:0]];
    end

    // Active table: append on load, compact on a done report
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD && load_ok) begin
            act_id_reg[act_count_reg[IDXW-1:0]]   <= ring_rd_reg[15:0];
            act_prio_reg[act_count_reg[IDXW-1:0]] <= ring_rd_reg[17:16];
        end else if (pop_fire && pop_cmd.op == OP_REPORT && report_ok
                     && pop_cmd.outcome == OUTCOME_DONE) begin
            for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
                if (IDXW'(i) >= dispatched_reg) begin
                    act_id_reg[i]   <= act_id_reg[i + 1];
                    act_prio_reg[i] <= act_prio_reg[i + 1];
                end
            end
        end
    end

    // Selection scan, one slot a cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_INIT) begin
            scan_idx_reg   <= '0;
            best_reg       <= sel_idx;
            best_prio_reg  <= sel_prio;
            best_id_reg    <= sel_id;
            stall_mode_reg <= stall_mode_now;
        end else if (state_reg == ST_SCAN) begin
            scan_idx_reg  <= scan_idx_reg + IDXW'(1);
            best_reg      <= fin_slot;
            best_prio_reg <= fin_prio;
            best_id_reg   <= fin_id;
        end
    end

    // Result payload for the current state
    always_comb begin
        res_next                = '0;
        res_next.dispatch_total = counter_reg;
        if (state_reg == ST_IDLE) begin
            if (pop_cmd.op == OP_ADD) begin
                res_next.accepted = !ring_full;
            end else if (pop_cmd.op == OP_REPORT) begin
                res_next.yield_hint = report_ok && pop_cmd.outcome == OUTCOME_STALLED
                                      && CNTW'(dispatched_reg) == stalled_reg;
            end
        end else if (state_reg == ST_INIT) begin
            res_next.idle = 1'b1;
        end else if (state_reg == ST_SCAN) begin
            res_next.slot           = 4'(fin_slot);
            res_next.chosen_id      = fin_id;
            res_next.run_whole      = (fin_prio == full_run_reg);
            res_next.dispatch_total = counter_reg + 32'd1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE && pop_fire)
            || (state_reg == ST_INIT && act_count_reg == '0)
            || (state_reg == ST_SCAN && scan_last)) begin
            m_res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    // Table never holds more lists than it has slots
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        act_count_reg <= DEPTH_C)
        else $error("active count beyond table depth");

    // Ring never overfills
    a_ring_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_fill <= DEPTH_C)
        else $error("ring fill beyond depth");

    // A finished scan leaves a dispatch awaiting its report
    a_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && scan_last) |=> (pending_reg && m_tvalid_reg))
        else $error("dispatch not marked pending");

    // A pick leaves the table non-empty or reports idle
    a_pick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT && act_count_reg == '0) |=> (m_tvalid_reg && m_res_reg.idle))
        else $error("idle pick without idle result");
`endif

endmodule

// ----- rtl/job_list_priority_scheduler.sv -----
// Path: an add, report or unknown item passes the front register and the queue
//   before the engine registers its result; a pick passes the load and init
//   states and, with a non-empty table, a one-slot-a-cycle scan of the lists.
// Flow: one item at a time in the engine, which takes no new item until idle.
// Reset: synchronous active-low aresetn empties ring, table and queue, clears
//   the stall mark and dispatch count, and sets full_run_level to 3.
// ----------------------------------------------------------------------------
// job_list_priority_scheduler
// Top level: input front end, command queue and scheduling engine.
// ----------------------------------------------------------------------------
module job_list_priority_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // list_id[15:0], list_priority, outcome
    input  logic [1:0]  s_tuser,    // func
    output logic        m_tvalid,
    input  logic        m_tready,
    // accepted, idle, slot, chosen_id, run_whole, yield_hint, dispatch_total
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data    // full_run_level
);
    import jlps_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;
    res_t m_res;

    assign cfg_ready = 1'b1;
    assign m_tdata   = m_res;

    jlps_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    jlps_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    jlps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

endmodule
